>>> src/svalloc_pkg.sv
// Types, constants and the control program of the sound voice allocator.
package svalloc_pkg;

    // Fixed field widths of the request and result beats.
    localparam int CHAN_W = 6;
    localparam int PRIO_W = 8;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_STOP     = 2'd1,
        OP_STOP_ALL = 2'd2,
        OP_RELEASE  = 2'd3
    } t_op;

    // Addresses of the control program steps.
    typedef enum logic [3:0] {
        S_IDLE  = 4'd0,
        S_KILL  = 4'd1,
        S_PICKZ = 4'd2,
        S_PICK  = 4'd3,
        S_FREE  = 4'd4,
        S_STEAL = 4'd5,
        S_STOP  = 4'd6,
        S_ALL   = 4'd7,
        S_REL   = 4'd8,
        S_DONE  = 4'd9
    } t_step;

    // What a step does with the sequencer.
    typedef enum logic [2:0] {
        K_DISPATCH = 3'd0,  // wait for a request, jump by operation
        K_SCAN     = 3'd1,  // walk the channel table until the condition hits or the table ends
        K_JUMPZ    = 3'd2,  // branch on a zero origin
        K_EXEC     = 3'd3,  // action on the requested channel, or on all channels
        K_EMIT     = 3'd4   // hand the result to the output register
    } t_kind;

    // Match condition tested against each channel during a scan.
    typedef enum logic [2:0] {
        C_NONE  = 3'd0,
        C_KILL  = 3'd1,
        C_PICK  = 3'd2,
        C_FREE  = 3'd3,
        C_STEAL = 3'd4,
        C_STOP  = 3'd5
    } t_cond;

    // Action taken on a hit or by an execute step.
    typedef enum logic [2:0] {
        A_NONE    = 3'd0,
        A_FREE    = 3'd1,
        A_GRANT   = 3'd2,
        A_STEAL   = 3'd3,
        A_STOP    = 3'd4,
        A_CLEAR   = 3'd5,
        A_RELEASE = 3'd6
    } t_act;

    // One control word. hit_next also serves as the taken branch and the
    // plain successor; miss_next is the fall-through of scans and branches.
    typedef struct packed {
        t_kind kind;
        t_cond cond;
        t_act  act;
        t_step hit_next;
        t_step miss_next;
    } t_uword;

    // The control program, one word per step.
    function automatic t_uword f_ucode(input t_step step);
        t_uword w;
        w = '{K_DISPATCH, C_NONE, A_NONE, S_IDLE, S_IDLE};
        unique case (step)
            S_IDLE:  w = '{K_DISPATCH, C_NONE,  A_NONE,    S_IDLE,  S_IDLE};
            S_KILL:  w = '{K_SCAN,     C_KILL,  A_FREE,    S_PICKZ, S_PICKZ};
            S_PICKZ: w = '{K_JUMPZ,    C_NONE,  A_NONE,    S_FREE,  S_PICK};
            S_PICK:  w = '{K_SCAN,     C_PICK,  A_FREE,    S_FREE,  S_FREE};
            S_FREE:  w = '{K_SCAN,     C_FREE,  A_GRANT,   S_DONE,  S_STEAL};
            S_STEAL: w = '{K_SCAN,     C_STEAL, A_STEAL,   S_DONE,  S_DONE};
            S_STOP:  w = '{K_SCAN,     C_STOP,  A_STOP,    S_DONE,  S_DONE};
            S_ALL:   w = '{K_EXEC,     C_NONE,  A_CLEAR,   S_DONE,  S_DONE};
            S_REL:   w = '{K_EXEC,     C_NONE,  A_RELEASE, S_DONE,  S_DONE};
            S_DONE:  w = '{K_EMIT,     C_NONE,  A_NONE,    S_IDLE,  S_IDLE};
            default: w = '{K_DISPATCH, C_NONE,  A_NONE,    S_IDLE,  S_IDLE};
        endcase
        return w;
    endfunction

    // Entry point of the program for each operation.
    function automatic t_step f_dispatch(input t_op op);
        t_step s;
        s = S_IDLE;
        unique case (op)
            OP_START:    s = S_KILL;
            OP_STOP:     s = S_STOP;
            OP_STOP_ALL: s = S_ALL;
            OP_RELEASE:  s = S_REL;
            default:     s = S_IDLE;
        endcase
        return s;
    endfunction

endpackage

>>> src/sound_voice_allocator_core.sv
// Sound channel allocator: a microcoded sequencer over a table of channels.
//
// Requests arrive on a valid/ready channel (i_in_valid, o_in_ready) and each
// one gives exactly one result beat on a valid/ready channel (o_out_valid,
// i_out_ready). A request is taken only while the sequencer waits in its idle
// step, so one request is worked at a time. A start request walks the channel
// table up to four times (kill, pickup, lowest free, steal), one channel per
// cycle through the registered read port of the channel memory. A stop by
// origin walks the table at most once; stop all and release need no walk.
// The next request is taken in the cycle after a result is loaded.
// The result sits in an output register; while the receiver stalls, the next
// request is still accepted and worked, and its result waits in the sequencer
// until the register empties. Reset frees every channel, clears the mode
// register and empties the output; it needs no clearing pass. i_cfg_we writes
// the compatibility mode at once and is meant for times when the block is idle.
module sound_voice_allocator_core
    import svalloc_pkg::*;
#(
    parameter int NUM_CHANNELS = 22,
    parameter int ORIGIN_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration.
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    // Request channel.
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_operation,
    input  logic [15:0]       i_origin_id,
    input  logic              i_is_pickup,
    input  logic [PRIO_W-1:0] i_priority_req,
    input  logic [CHAN_W-1:0] i_channel_index,
    // Result channel.
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_granted,
    output logic [CHAN_W-1:0] o_channel,
    output logic              o_stole,
    output logic              o_stopped_any
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
    localparam int MEM_W = ORIGIN_BITS + 1 + PRIO_W;
    localparam logic [CNT_W-1:0]  NUM_CNT = CNT_W'(NUM_CHANNELS);
    localparam logic [CHAN_W:0]   NUM_EXT = (CHAN_W + 1)'(NUM_CHANNELS);

    // Sequencer and control state.
    t_step                   r_step, n_step;
    logic [NUM_CHANNELS-1:0] r_busy;
    logic                    r_compat;
    logic [CNT_W-1:0]        r_addr;
    logic                    r_rd_vld;
    logic                    r_out_valid;

    // Request and channel payload.
    logic [ORIGIN_BITS-1:0]  r_org;
    logic                    r_pick;
    logic [PRIO_W-1:0]       r_prio;
    logic [CHAN_W-1:0]       r_req_idx;
    logic [MEM_W-1:0]        r_mem [NUM_CHANNELS];
    logic [ORIGIN_BITS-1:0]  r_rd_org;
    logic                    r_rd_pick;
    logic [PRIO_W-1:0]       r_rd_prio;
    logic [IDX_W-1:0]        r_rd_idx;

    // Result being built and the output register.
    logic                    r_granted, r_stole, r_stopped;
    logic [CHAN_W-1:0]       r_chan;
    logic                    r_out_granted, r_out_stole, r_out_stopped;
    logic [CHAN_W-1:0]       r_out_chan;

    // Decoded control.
    t_uword                  w_uw;
    logic                    w_issue, w_hit, w_cond_ok, w_busy_rd;
    logic                    w_org_eq, w_pick_eq, w_rel_ok;
    logic                    w_accept, w_act_en, w_load_out, w_write;
    logic [IDX_W-1:0]        w_act_idx;

    // Condition test on the channel just read, and the next step.
    always_comb begin
        w_uw      = f_ucode(r_step);
        w_issue   = (w_uw.kind == K_SCAN) && (r_addr < NUM_CNT);
        w_org_eq  = (r_rd_org == r_org);
        w_pick_eq = (r_rd_pick == r_pick);
        w_busy_rd = r_busy[r_rd_idx];
        w_rel_ok  = ({1'b0, r_req_idx} < NUM_EXT);
        w_cond_ok = 1'b0;
        unique case (w_uw.cond)
            C_KILL:  w_cond_ok = w_busy_rd && w_org_eq && (r_compat || w_pick_eq);
            C_PICK:  w_cond_ok = w_busy_rd && w_org_eq && w_pick_eq;
            C_FREE:  w_cond_ok = !w_busy_rd;
            C_STEAL: w_cond_ok = (r_rd_prio >= r_prio);
            C_STOP:  w_cond_ok = w_busy_rd && w_org_eq;
            default: w_cond_ok = 1'b0;
        endcase
        w_hit     = (w_uw.kind == K_SCAN) && r_rd_vld && w_cond_ok;
        w_act_idx = (w_uw.kind == K_EXEC) ? r_req_idx[IDX_W-1:0] : r_rd_idx;

        n_step     = r_step;
        w_accept   = 1'b0;
        w_act_en   = 1'b0;
        w_load_out = 1'b0;
        o_in_ready = (w_uw.kind == K_DISPATCH);
        unique case (w_uw.kind)
            K_DISPATCH: begin
                w_accept = i_in_valid;
                if (i_in_valid) begin
                    n_step = f_dispatch(t_op'(i_operation));
                end
            end
            K_SCAN: begin
                if (w_hit) begin
                    w_act_en = 1'b1;
                    n_step   = w_uw.hit_next;
                end else if (!w_issue) begin
                    n_step = w_uw.miss_next;
                end
            end
            K_JUMPZ: begin
                n_step = (r_org == '0) ? w_uw.hit_next : w_uw.miss_next;
            end
            K_EXEC: begin
                w_act_en = 1'b1;
                n_step   = w_uw.hit_next;
            end
            K_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_step     = w_uw.hit_next;
                end
            end
            default: n_step = S_IDLE;
        endcase
        w_write = w_act_en && ((w_uw.act == A_GRANT) || (w_uw.act == A_STEAL));
    end

    // Step counter and scan address; a new step restarts the walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= S_IDLE;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_step <= n_step;
            if (n_step != r_step) begin
                r_addr   <= '0;
                r_rd_vld <= 1'b0;
            end else begin
                r_addr   <= r_addr + CNT_W'(w_issue);
                r_rd_vld <= w_issue;
            end
        end
    end

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compat <= 1'b0;
        end else if (i_cfg_we) begin
            r_compat <= i_cfg_wdata;
        end
    end

    // Busy flags of the channels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else if (w_act_en) begin
            case (w_uw.act) inside
                A_FREE, A_STOP:   r_busy[w_act_idx] <= 1'b0;
                A_GRANT, A_STEAL: r_busy[w_act_idx] <= 1'b1;
                A_CLEAR:          r_busy <= '0;
                A_RELEASE: begin
                    if (w_rel_ok) begin
                        r_busy[w_act_idx] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Channel memory: origin, pickup flag and priority, registered read.
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[w_act_idx] <= {r_org, r_pick, r_prio};
        end
        if (w_issue) begin
            {r_rd_org, r_rd_pick, r_rd_prio} <= r_mem[r_addr[IDX_W-1:0]];
            r_rd_idx <= r_addr[IDX_W-1:0];
        end
    end

    // Request capture and result build-up.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_org     <= ORIGIN_BITS'(i_origin_id);
            r_pick    <= i_is_pickup;
            r_prio    <= i_priority_req;
            r_req_idx <= i_channel_index;
            r_granted <= 1'b0;
            r_stole   <= 1'b0;
            r_stopped <= 1'b0;
            r_chan    <= '0;
        end else if (w_act_en) begin
            case (w_uw.act) inside
                A_GRANT: begin
                    r_granted <= 1'b1;
                    r_chan    <= CHAN_W'(w_act_idx);
                end
                A_STEAL: begin
                    r_granted <= 1'b1;
                    r_stole   <= 1'b1;
                    r_chan    <= CHAN_W'(w_act_idx);
                end
                A_STOP: begin
                    r_stopped <= 1'b1;
                    r_chan    <= CHAN_W'(w_act_idx);
                end
                default: ;
            endcase
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_granted <= r_granted;
            r_out_chan    <= r_chan;
            r_out_stole   <= r_stole;
            r_out_stopped <= r_stopped;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_granted     = r_out_granted;
    assign o_channel     = r_out_chan;
    assign o_stole       = r_out_stole;
    assign o_stopped_any = r_out_stopped;

`ifndef SYNTHESIS
    // A steal always comes with a grant.
    a_stole_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stole |-> o_granted)
        else $error("stole set without granted");

    // A beat never reports both a grant and a stop.
    a_grant_stop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_granted && o_stopped_any))
        else $error("granted and stopped_any both set");

    // The scan address never exceeds the number of channels.
    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr <= NUM_CNT)
        else $error("scan address out of range");

    // The sequencer leaves its idle step only on an accepted request.
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_IDLE) && !i_in_valid |=> (r_step == S_IDLE))
        else $error("sequencer left idle without a request");

    // Handing a result over fills the output register and returns to idle.
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> r_out_valid && (r_step == S_IDLE))
        else $error("result hand-over failed");
`endif

endmodule
